// File: rtl/rbtt_pkg.sv
// Shared constants, codes and controller/datapath interface types for the receive bitmap tracker.
package rbtt_pkg;

   localparam int MAX_PKTS  = 1024;
   localparam int WORD_W    = 32;
   localparam int ROWS      = MAX_PKTS / WORD_W;
   localparam int ROW_W     = $clog2(ROWS);
   localparam int BIT_W     = $clog2(WORD_W);
   localparam int POS_W     = ROW_W + BIT_W;
   localparam int CNT_W     = POS_W + 1;
   localparam int TOK_W     = 16;
   localparam int ECHO_W    = TOK_W + 1;
   localparam int DIFF_W    = TOK_W + 2;
   localparam int FUNC_W    = 2;
   localparam int CSR_IDX_W = 1;
   localparam int MODC_W    = $clog2(CNT_W);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ARRIVE = 2'd0,
      FUNC_TOKEN  = 2'd1,
      FUNC_RELAX  = 2'd2
   } func_type;

   localparam logic [CSR_IDX_W-1:0] CSR_FLOW_PKTS    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOKEN_WINDOW = 1'b1;

   typedef struct packed {
      logic cap;
      logic arr_read;
      logic arr_write;
      logic dup_set;
      logic mod_init;
      logic mod_step;
      logic scan_init;
      logic scan_from_cp;
      logic scan_read;
      logic scan_eval;
      logic cp_commit;
      logic tok_commit;
      logic echo_fin;
      logic relax;
      logic out_load;
   } rbtt_cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              arr_ok;
      logic              bit_set;
      logic              mod_needed;
      logic              mod_last;
      logic              scan_empty;
      logic              scan_hit;
      logic              scan_last;
      logic              scan_found;
      logic              out_free;
   } rbtt_status_type;

endpackage

// File: rtl/rbtt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rbtt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: rtl/rbtt_ctrl.sv
// Sequencing state machine for the receive bitmap tracker.
module rbtt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output rbtt_pkg::rbtt_cmd_type   cmd,
   input  rbtt_pkg::rbtt_status_type status
);
   import rbtt_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ARR_CHK,
      ST_ARR_FIN,
      ST_MOD,
      ST_TOK_INIT,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_SCAN_END,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      PASS_TOK_FIRST,
      PASS_TOK_SECOND,
      PASS_CP
   } pass_type;

   state_type state_ff, state_in;
   pass_type  pass_ff, pass_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.cap  = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (status.func)
               FUNC_ARRIVE: begin
                  if (status.arr_ok) begin
                     cmd.arr_read = 1'b1;
                     state_in     = ST_ARR_CHK;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
               FUNC_TOKEN: begin
                  pass_in = PASS_TOK_FIRST;
                  if (status.mod_needed) begin
                     cmd.mod_init = 1'b1;
                     state_in     = ST_MOD;
                  end else begin
                     cmd.scan_init = 1'b1;
                     state_in      = ST_SCAN_RD;
                  end
               end
               FUNC_RELAX: begin
                  cmd.relax = 1'b1;
                  state_in  = ST_FINISH;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_ARR_CHK: begin
            if (status.bit_set) begin
               cmd.dup_set = 1'b1;
               state_in    = ST_ARR_FIN;
            end else begin
               cmd.arr_write    = 1'b1;
               cmd.scan_init    = 1'b1;
               cmd.scan_from_cp = 1'b1;
               pass_in          = PASS_CP;
               state_in         = ST_SCAN_RD;
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (status.mod_last) begin
               state_in = ST_TOK_INIT;
            end
         end
         ST_TOK_INIT: begin
            cmd.scan_init = 1'b1;
            state_in      = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            if (status.scan_empty) begin
               state_in = ST_SCAN_END;
            end else begin
               cmd.scan_read = 1'b1;
               state_in      = ST_SCAN_EV;
            end
         end
         ST_SCAN_EV: begin
            cmd.scan_eval = 1'b1;
            if (status.scan_hit || status.scan_last) begin
               state_in = ST_SCAN_END;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_END: begin
            unique case (pass_ff)
               PASS_CP: begin
                  cmd.cp_commit = 1'b1;
                  state_in      = ST_ARR_FIN;
               end
               PASS_TOK_FIRST: begin
                  if (status.scan_found) begin
                     cmd.tok_commit = 1'b1;
                     state_in       = ST_FINISH;
                  end else begin
                     cmd.scan_init    = 1'b1;
                     cmd.scan_from_cp = 1'b1;
                     pass_in          = PASS_TOK_SECOND;
                     state_in         = ST_SCAN_RD;
                  end
               end
               default: begin
                  cmd.tok_commit = 1'b1;
                  state_in       = ST_FINISH;
               end
            endcase
         end
         ST_ARR_FIN: begin
            cmd.echo_fin = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pass_ff  <= PASS_TOK_FIRST;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
   end

endmodule

// File: rtl/rbtt_dp.sv
// Datapath of the receive bitmap tracker: flow state, bitmap RAM, word scanner and result register.
module rbtt_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [rbtt_pkg::FUNC_W-1:0]          req_func,
   input  logic [rbtt_pkg::POS_W-1:0]           req_pkt_seq,
   input  logic [rbtt_pkg::TOK_W-1:0]           req_token_seq,
   input  logic                                 req_free_tok,
   input  logic                                 csr_wr_en,
   input  logic [rbtt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rbtt_pkg::CNT_W-1:0]           csr_wdata,
   input  rbtt_pkg::rbtt_cmd_type               cmd,
   output rbtt_pkg::rbtt_status_type            status,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic [rbtt_pkg::POS_W-1:0]           rsp_token_pkt_seq,
   output logic [rbtt_pkg::TOK_W-1:0]           rsp_token_number,
   output logic [rbtt_pkg::CNT_W-1:0]           rsp_remaining,
   output logic [rbtt_pkg::TOK_W-1:0]           rsp_token_gap,
   output logic                                 rsp_gap_error,
   output logic                                 rsp_fin_now,
   output logic                                 rsp_done_res,
   output logic                                 rsp_duplicate,
   output logic                                 rsp_none_missing,
   output logic [rbtt_pkg::CNT_W-1:0]           rsp_in_order_point
);
   import rbtt_pkg::*;

   function automatic logic [BIT_W-1:0] first_one(input logic [WORD_W-1:0] v);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int j = WORD_W - 1; j >= 0; j--) begin
         if (v[j]) begin
            idx = BIT_W'(j);
         end
      end
      return idx;
   endfunction

   // configuration
   logic [CNT_W-1:0] flow_ff, flow_in;
   logic [CNT_W-1:0] window_ff, window_in;

   // captured word
   logic [FUNC_W-1:0] func_ff;
   logic [POS_W-1:0]  dseq_ff;
   logic [TOK_W-1:0]  tseq_ff;
   logic              free_ff;

   // flow state
   logic [CNT_W-1:0]         rt_ff, rt_in;
   logic [CNT_W-1:0]         cp_ff, cp_in;
   logic signed [ECHO_W-1:0] he_ff, he_in;
   logic [TOK_W-1:0]         ti_ff, ti_in;
   logic [CNT_W-1:0]         lt_next_ff, lt_next_in;
   logic                     fin_flag_ff, fin_flag_in;
   logic [ROWS-1:0]          row_valid_ff, row_valid_in;
   logic                     rd_valid_ff, rd_valid_in;

   // wrap reduction
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [MODC_W-1:0] mod_cnt_ff, mod_cnt_in;

   // scanner
   logic [ROW_W-1:0] scan_row_ff, scan_row_in;
   logic [BIT_W-1:0] scan_lo_ff, scan_lo_in;
   logic             scan_empty_ff, scan_empty_in;
   logic             hit_ff, hit_in;
   logic [POS_W-1:0] hit_pos_ff, hit_pos_in;

   // per-word results
   logic [POS_W-1:0] res_dseq_ff, res_dseq_in;
   logic [TOK_W-1:0] res_num_ff, res_num_in;
   logic             res_none_ff, res_none_in;
   logic             res_dup_ff, res_dup_in;
   logic             res_fin_ff, res_fin_in;

   logic rsp_valid_ff, rsp_valid_in;

   logic [CNT_W-1:0]         fp;
   logic [POS_W-1:0]         fp_m1;
   logic [ROW_W-1:0]         last_row;
   logic                     ram_rd_en;
   logic [ROW_W-1:0]         ram_rd_addr;
   logic [WORD_W-1:0]        ram_rd_data;
   logic [WORD_W-1:0]        word;
   logic [WORD_W-1:0]        wr_word;
   logic [WORD_W-1:0]        lo_mask;
   logic [WORD_W-1:0]        lim_mask;
   logic [WORD_W-1:0]        miss;
   logic [CNT_W-1:0]         room;
   logic [CNT_W-1:0]         r2;
   logic [CNT_W-1:0]         scan_start;
   logic                     mod_needed;
   logic signed [DIFF_W-1:0] diff;
   logic signed [DIFF_W-1:0] diff_m1;
   logic [TOK_W-1:0]         gap;
   logic [CNT_W-1:0]         remaining;

   always_comb begin
      if (flow_ff == '0) begin
         fp = CNT_W'(1);
      end else if (flow_ff > CNT_W'(MAX_PKTS)) begin
         fp = CNT_W'(MAX_PKTS);
      end else begin
         fp = flow_ff;
      end
   end

   assign fp_m1      = POS_W'(fp - CNT_W'(1));
   assign last_row   = fp_m1[POS_W-1:BIT_W];
   assign mod_needed = (lt_next_ff >= fp);

   assign ram_rd_en   = cmd.arr_read | cmd.scan_read;
   assign ram_rd_addr = cmd.scan_read ? scan_row_ff : dseq_ff[POS_W-1:BIT_W];
   assign word        = rd_valid_ff ? ram_rd_data : '0;
   assign wr_word     = word | (WORD_W'(1) << dseq_ff[BIT_W-1:0]);

   rbtt_ram #(
      .WIDTH(WORD_W),
      .DEPTH(ROWS)
   ) u_map (
      .clock  (clock),
      .wr_en  (cmd.arr_write),
      .wr_addr(dseq_ff[POS_W-1:BIT_W]),
      .wr_data(wr_word),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign room = fp - {1'b0, scan_row_ff, {BIT_W{1'b0}}};

   always_comb begin
      for (int j = 0; j < WORD_W; j++) begin
         lo_mask[j]  = (BIT_W'(j) >= scan_lo_ff);
         lim_mask[j] = (CNT_W'(j) < room);
      end
   end

   assign miss = ~word & lo_mask & lim_mask;
   assign r2   = {rem_ff[CNT_W-2:0], lt_next_ff[mod_cnt_ff]};

   assign scan_start = cmd.scan_from_cp ? cp_ff : (mod_needed ? rem_ff : lt_next_ff);

   assign diff    = $signed({2'b00, ti_ff}) - $signed({he_ff[ECHO_W-1], he_ff});
   assign diff_m1 = diff - DIFF_W'(1);

   always_comb begin
      if (diff[DIFF_W-1] || (diff == '0)) begin
         gap = '0;
      end else if (diff_m1[DIFF_W-1:TOK_W] != '0) begin
         gap = '1;
      end else begin
         gap = diff_m1[TOK_W-1:0];
      end
   end

   assign remaining = (rt_ff >= fp) ? '0 : fp - rt_ff;

   always_comb begin
      status            = '0;
      status.func       = func_ff;
      status.arr_ok     = !fin_flag_ff && ({1'b0, dseq_ff} < fp);
      status.bit_set    = word[dseq_ff[BIT_W-1:0]];
      status.mod_needed = mod_needed;
      status.mod_last   = (mod_cnt_ff == '0);
      status.scan_empty = scan_empty_ff;
      status.scan_hit   = |miss;
      status.scan_last  = (scan_row_ff == last_row);
      status.scan_found = hit_ff;
      status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      flow_in       = flow_ff;
      window_in     = window_ff;
      rt_in         = rt_ff;
      cp_in         = cp_ff;
      he_in         = he_ff;
      ti_in         = ti_ff;
      lt_next_in    = lt_next_ff;
      fin_flag_in   = fin_flag_ff;
      row_valid_in  = row_valid_ff;
      rd_valid_in   = rd_valid_ff;
      rem_in        = rem_ff;
      mod_cnt_in    = mod_cnt_ff;
      scan_row_in   = scan_row_ff;
      scan_lo_in    = scan_lo_ff;
      scan_empty_in = scan_empty_ff;
      hit_in        = hit_ff;
      hit_pos_in    = hit_pos_ff;
      res_dseq_in   = res_dseq_ff;
      res_num_in    = res_num_ff;
      res_none_in   = res_none_ff;
      res_dup_in    = res_dup_ff;
      res_fin_in    = res_fin_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FLOW_PKTS:    flow_in   = csr_wdata;
            CSR_TOKEN_WINDOW: window_in = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.cap) begin
         res_dseq_in = '0;
         res_num_in  = '0;
         res_none_in = 1'b0;
         res_dup_in  = 1'b0;
         res_fin_in  = 1'b0;
      end

      if (ram_rd_en) begin
         rd_valid_in = row_valid_ff[ram_rd_addr];
      end

      if (cmd.arr_write) begin
         rt_in                                  = rt_ff + CNT_W'(1);
         row_valid_in[dseq_ff[POS_W-1:BIT_W]]   = 1'b1;
      end

      if (cmd.dup_set) begin
         res_dup_in = 1'b1;
      end

      if (cmd.mod_init) begin
         rem_in     = '0;
         mod_cnt_in = MODC_W'(CNT_W - 1);
      end

      if (cmd.mod_step) begin
         rem_in     = (r2 >= fp) ? r2 - fp : r2;
         mod_cnt_in = mod_cnt_ff - MODC_W'(1);
      end

      if (cmd.scan_init) begin
         scan_row_in   = scan_start[POS_W-1:BIT_W];
         scan_lo_in    = scan_start[BIT_W-1:0];
         scan_empty_in = (scan_start >= fp);
         hit_in        = 1'b0;
      end

      if (cmd.scan_eval) begin
         hit_in      = |miss;
         hit_pos_in  = {scan_row_ff, first_one(miss)};
         scan_row_in = scan_row_ff + ROW_W'(1);
         scan_lo_in  = '0;
      end

      if (cmd.cp_commit) begin
         if (hit_ff) begin
            cp_in = {1'b0, hit_pos_ff};
         end else if (cp_ff < fp) begin
            cp_in = fp;
         end
      end

      if (cmd.tok_commit) begin
         if (hit_ff) begin
            res_dseq_in = hit_pos_ff;
            if (!free_ff) begin
               res_num_in = ti_ff;
               ti_in      = ti_ff + TOK_W'(1);
               lt_next_in = {1'b0, hit_pos_ff} + CNT_W'(1);
            end
         end else begin
            res_none_in = 1'b1;
         end
      end

      if (cmd.echo_fin) begin
         if (!free_ff && ($signed({1'b0, tseq_ff}) > he_ff)) begin
            he_in = $signed({1'b0, tseq_ff});
         end
         if (rt_ff >= fp) begin
            res_fin_in  = 1'b1;
            fin_flag_in = 1'b1;
         end
      end

      if (cmd.relax) begin
         he_in = $signed({1'b0, ti_ff}) - $signed({{(ECHO_W-CNT_W){1'b0}}, window_ff});
      end

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flow_ff      <= CNT_W'(1);
         window_ff    <= CNT_W'(1);
         rt_ff        <= '0;
         cp_ff        <= '0;
         he_ff        <= '1;
         ti_ff        <= '0;
         lt_next_ff   <= '0;
         fin_flag_ff  <= 1'b0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         flow_ff      <= flow_in;
         window_ff    <= window_in;
         rt_ff        <= rt_in;
         cp_ff        <= cp_in;
         he_ff        <= he_in;
         ti_ff        <= ti_in;
         lt_next_ff   <= lt_next_in;
         fin_flag_ff  <= fin_flag_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         func_ff <= req_func;
         dseq_ff <= req_pkt_seq;
         tseq_ff <= req_token_seq;
         free_ff <= req_free_tok;
      end
      rd_valid_ff   <= rd_valid_in;
      rem_ff        <= rem_in;
      mod_cnt_ff    <= mod_cnt_in;
      scan_row_ff   <= scan_row_in;
      scan_lo_ff    <= scan_lo_in;
      scan_empty_ff <= scan_empty_in;
      hit_ff        <= hit_in;
      hit_pos_ff    <= hit_pos_in;
      res_dseq_ff   <= res_dseq_in;
      res_num_ff    <= res_num_in;
      res_none_ff   <= res_none_in;
      res_dup_ff    <= res_dup_in;
      res_fin_ff    <= res_fin_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_token_pkt_seq  <= res_dseq_ff;
         rsp_token_number   <= res_num_ff;
         rsp_remaining      <= remaining;
         rsp_token_gap      <= gap;
         rsp_gap_error      <= diff[DIFF_W-1];
         rsp_fin_now        <= res_fin_ff;
         rsp_done_res       <= fin_flag_ff;
         rsp_duplicate      <= res_dup_ff;
         rsp_none_missing   <= res_none_ff;
         rsp_in_order_point <= cp_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/receive_bitmap_token_tracker_core.sv
// Top level of the receive bitmap tracker: controller, datapath and ports.
//
// One word is worked on at a time, and the next word is taken while a finished
// result still waits in the output register. The received bitmap lives in a
// 32-word by 32-bit RAM with one valid bit per row, so it reads as all clear
// after reset without any clearing pass. An arrival reads its bitmap word; a
// new packet sets its bit and scans the bitmap words from the in-order point
// to move that point forward, a duplicate flags the result without a write,
// and an ignored arrival goes straight to the result. A token request runs
// the find-first-zero scanner, with a second pass when the scan wraps back to
// the in-order point (a pass with nothing to read when the in-order point
// already sits at the flow size), and first has the shift-subtract unit reduce
// the previous token's position when the position after its packet lies at or
// past the flow size. Relax and unused codes go straight to the result. The
// scanner reads one RAM word and evaluates it before it reads the next.
module receive_bitmap_token_tracker_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [rbtt_pkg::FUNC_W-1:0]    req_func,
   input  logic [rbtt_pkg::POS_W-1:0]     req_pkt_seq,
   input  logic [rbtt_pkg::TOK_W-1:0]     req_token_seq,
   input  logic                           req_free_tok,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rbtt_pkg::POS_W-1:0]     rsp_token_pkt_seq,
   output logic [rbtt_pkg::TOK_W-1:0]     rsp_token_number,
   output logic [rbtt_pkg::CNT_W-1:0]     rsp_remaining,
   output logic [rbtt_pkg::TOK_W-1:0]     rsp_token_gap,
   output logic                           rsp_gap_error,
   output logic                           rsp_fin_now,
   output logic                           rsp_done_res,
   output logic                           rsp_duplicate,
   output logic                           rsp_none_missing,
   output logic [rbtt_pkg::CNT_W-1:0]     rsp_in_order_point,
   input  logic                           csr_wr_en,
   input  logic [rbtt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rbtt_pkg::CNT_W-1:0]     csr_wdata
);
   import rbtt_pkg::*;

   rbtt_cmd_type    cmd;
   rbtt_status_type status;

   rbtt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .cmd      (cmd),
      .status   (status)
   );

   rbtt_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_func          (req_func),
      .req_pkt_seq       (req_pkt_seq),
      .req_token_seq     (req_token_seq),
      .req_free_tok      (req_free_tok),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .status            (status),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_token_pkt_seq (rsp_token_pkt_seq),
      .rsp_token_number  (rsp_token_number),
      .rsp_remaining     (rsp_remaining),
      .rsp_token_gap     (rsp_token_gap),
      .rsp_gap_error     (rsp_gap_error),
      .rsp_fin_now       (rsp_fin_now),
      .rsp_done_res      (rsp_done_res),
      .rsp_duplicate     (rsp_duplicate),
      .rsp_none_missing  (rsp_none_missing),
      .rsp_in_order_point(rsp_in_order_point)
   );

endmodule

// File: rtl/rbtt_checker.sv
// Port-level assertions for the receive bitmap tracker and their bind to the top level.
module rbtt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [rbtt_pkg::POS_W-1:0]     rsp_token_pkt_seq,
   input logic [rbtt_pkg::TOK_W-1:0]     rsp_token_number,
   input logic [rbtt_pkg::CNT_W-1:0]     rsp_remaining,
   input logic [rbtt_pkg::TOK_W-1:0]     rsp_token_gap,
   input logic                           rsp_gap_error,
   input logic                           rsp_fin_now,
   input logic                           rsp_done_res,
   input logic                           rsp_none_missing,
   input logic [rbtt_pkg::CNT_W-1:0]     rsp_in_order_point
);
   import rbtt_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_number)
         && $stable(rsp_in_order_point) && $stable(rsp_token_gap))
      else $error("result word changed while stalled");

   a_gap_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_gap_error |-> rsp_token_gap == '0)
      else $error("token gap nonzero with gap error");

   a_fin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fin_now |-> rsp_done_res && rsp_remaining == '0)
      else $error("FIN without finished flow");

   a_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_none_missing |-> rsp_token_number == '0
         && rsp_token_pkt_seq == '0)
      else $error("token issued with no missing packet");

endmodule

bind receive_bitmap_token_tracker_core rbtt_checker u_rbtt_checker (.*);
